/* rtl/core/lpbd_pkg.sv */
// ----------------------------------------------------------------------------
// Length-prefixed bit deframer package
// Shared constants and the result type of the deframer.
// ----------------------------------------------------------------------------
package lpbd_pkg;

    localparam int LPBD_LENGTH_FIELD_BITS = 20;
    localparam int LPBD_WORD_BITS         = 32;
    localparam int LPBD_BYTE_BITS         = 8;
    localparam int LPBD_MAX_RESULTS       = 5;
    localparam int LPBD_SKIP_W            = 5;
    localparam int LPBD_NBITS_W           = 4;
    localparam logic [LPBD_SKIP_W-1:0] LPBD_SKIP_RESET = 5'd8;

    typedef struct packed {
        logic [LPBD_BYTE_BITS-1:0] data_byte;
        logic [LPBD_NBITS_W-1:0]   byte_bits;
        logic                      frame_last;
        logic                      frame_empty;
    } t_lpbd_result;

endpackage

/* rtl/core/lpbd_bit_engine.sv */
// ----------------------------------------------------------------------------
// Deframer bit engine
// Takes one stream bit per step, gathers the length field, then packs the
// payload into bytes and reports a result whenever a byte or a frame ends.
// ----------------------------------------------------------------------------
module lpbd_bit_engine
    import lpbd_pkg::*;
#(
    parameter int LENGTH_FIELD_BITS = LPBD_LENGTH_FIELD_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_step,
    input  logic         i_bit,
    output logic         o_emit,
    output t_lpbd_result o_result
);

    localparam int LEN_W = LENGTH_FIELD_BITS;
    localparam int CNT_W = $clog2(LENGTH_FIELD_BITS + 1);

    logic             r_in_payload, n_in_payload;
    logic [LEN_W-1:0] r_acc, n_acc;
    logic [CNT_W-1:0] r_acc_bits, n_acc_bits;
    logic [LEN_W-1:0] r_rem, n_rem;

    logic [LEN_W-1:0]          shifted;
    logic [CNT_W-1:0]          bits_inc;
    logic [LEN_W-1:0]          rem_dec;
    logic [LPBD_BYTE_BITS-1:0] low_byte;
    logic [2:0]                pad;

    always_comb begin
        shifted      = {r_acc[LEN_W-2:0], i_bit};
        bits_inc     = r_acc_bits + 1'b1;
        rem_dec      = (r_rem != '0) ? r_rem - 1'b1 : r_rem;
        low_byte     = shifted[LPBD_BYTE_BITS-1:0];
        pad          = 3'(4'(LPBD_BYTE_BITS) - bits_inc[LPBD_NBITS_W-1:0]);
        n_in_payload = r_in_payload;
        n_acc        = shifted;
        n_acc_bits   = bits_inc;
        n_rem        = r_rem;
        o_emit       = 1'b0;
        o_result     = '0;
        if (!r_in_payload) begin
            if (bits_inc >= CNT_W'(LENGTH_FIELD_BITS)) begin
                n_acc      = '0;
                n_acc_bits = '0;
                if (shifted == '0) begin
                    o_emit               = 1'b1;
                    o_result.frame_last  = 1'b1;
                    o_result.frame_empty = 1'b1;
                end else begin
                    n_in_payload = 1'b1;
                    n_rem        = shifted;
                end
            end
        end else begin
            n_acc = LEN_W'(low_byte);
            n_rem = rem_dec;
            if (bits_inc >= CNT_W'(LPBD_BYTE_BITS) || rem_dec == '0) begin
                o_emit              = 1'b1;
                o_result.data_byte  = low_byte << pad;
                o_result.byte_bits  = bits_inc[LPBD_NBITS_W-1:0];
                o_result.frame_last = (rem_dec == '0);
                n_acc               = '0;
                n_acc_bits          = '0;
                if (rem_dec == '0) begin
                    n_in_payload = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_acc        <= '0;
            r_acc_bits   <= '0;
            r_rem        <= '0;
        end else if (i_step) begin
            r_in_payload <= n_in_payload;
            r_acc        <= n_acc;
            r_acc_bits   <= n_acc_bits;
            r_rem        <= n_rem;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> r_acc_bits < CNT_W'(LPBD_BYTE_BITS))
        else $error("Payload bit count has passed a whole byte.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> r_rem != '0)
        else $error("Payload active with no bits left.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit && !o_result.frame_empty |-> r_in_payload)
        else $error("Payload byte reported outside a payload.");

endmodule

/* rtl/core/length_prefixed_bit_deframer_unit.sv */
// Latency: a result is registered at the end of the cycle that takes its last bit; the first
// bit of a word is taken, at the earliest, in the cycle after the word transaction is accepted.
// Word transactions do not overlap: a new word is accepted only after the word shift register
// has passed on every bit of the last, skipped bits included, one per cycle unless stalled.
// Output back-pressure pauses the bit engine only on a step that produces a result.
// Reset is synchronous and active low; it clears all control state and sets the skip to 8.
// ----------------------------------------------------------------------------
// Length-prefixed bit deframer
// Splits a stream of 32-bit words into length-prefixed frames and delivers
// each frame's payload as bytes, one bit of the stream per cycle unless stalled.
// ----------------------------------------------------------------------------
module length_prefixed_bit_deframer_unit
    import lpbd_pkg::*;
#(
    parameter int LENGTH_FIELD_BITS = LPBD_LENGTH_FIELD_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [LPBD_SKIP_W-1:0]    i_cfg_start_skip_bits,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [LPBD_WORD_BITS-1:0] i_stream_word,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [LPBD_BYTE_BITS-1:0] o_data_byte,
    output logic [LPBD_NBITS_W-1:0]   o_byte_bits,
    output logic                      o_frame_last,
    output logic                      o_frame_empty
);

    localparam int POS_W = $clog2(LPBD_WORD_BITS + 1);
    localparam int RES_W = $clog2(LPBD_MAX_RESULTS + 1);

    logic                      r_busy;
    logic [POS_W-1:0]          r_cnt;
    logic [LPBD_SKIP_W-1:0]    r_drop;
    logic [LPBD_WORD_BITS-1:0] r_word;
    logic                      r_first_seen;
    logic [LPBD_SKIP_W-1:0]    r_skip;
    logic [RES_W-1:0]          r_res_cnt;
    logic                      r_out_valid;
    t_lpbd_result              r_out;

    logic         accept_in;
    logic         dropping;
    logic         slot_free;
    logic         res_full;
    logic         step;
    logic         eng_step;
    logic         eng_emit;
    logic         load_out;
    t_lpbd_result eng_result;

    assign accept_in = i_in_valid && !r_busy;
    assign dropping  = (r_drop != '0);
    assign slot_free = !r_out_valid || i_out_ready;
    assign res_full  = (r_res_cnt >= RES_W'(LPBD_MAX_RESULTS));
    assign step      = r_busy && (dropping || !eng_emit || slot_free || res_full);
    assign eng_step  = step && !dropping;
    assign load_out  = eng_step && eng_emit && !res_full;

    lpbd_bit_engine #(
        .LENGTH_FIELD_BITS(LENGTH_FIELD_BITS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (eng_step),
        .i_bit   (r_word[LPBD_WORD_BITS-1]),
        .o_emit  (eng_emit),
        .o_result(eng_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_cnt        <= '0;
            r_drop       <= '0;
            r_first_seen <= 1'b0;
            r_res_cnt    <= '0;
        end else if (accept_in) begin
            r_busy       <= 1'b1;
            r_cnt        <= POS_W'(LPBD_WORD_BITS);
            r_drop       <= r_first_seen ? '0 : r_skip;
            r_first_seen <= 1'b1;
            r_res_cnt    <= '0;
        end else if (step) begin
            r_cnt <= r_cnt - 1'b1;
            if (dropping) begin
                r_drop <= r_drop - 1'b1;
            end
            if (r_cnt == POS_W'(1)) begin
                r_busy <= 1'b0;
            end
            if (load_out) begin
                r_res_cnt <= r_res_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_word <= i_stream_word;
        end else if (step) begin
            r_word <= {r_word[LPBD_WORD_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= LPBD_SKIP_RESET;
        end else if (i_cfg_valid) begin
            r_skip <= i_cfg_start_skip_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= eng_result;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_in_ready    = !r_busy;
    assign o_out_valid   = r_out_valid;
    assign o_data_byte   = r_out.data_byte;
    assign o_byte_bits   = r_out.byte_bits;
    assign o_frame_last  = r_out.frame_last;
    assign o_frame_empty = r_out.frame_empty;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_cnt == '0 && r_drop == '0)
        else $error("Word counters not cleared at the end of a transaction.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> slot_free)
        else $error("Result written over an output that has not been taken.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.frame_empty |->
            r_out.frame_last && r_out.byte_bits == '0 && r_out.data_byte == '0)
        else $error("Malformed empty-frame result.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.frame_empty |->
            r_out.byte_bits != '0 && r_out.byte_bits <= LPBD_NBITS_W'(LPBD_BYTE_BITS))
        else $error("Byte bit count out of range.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_drop != '0 |-> r_drop < r_cnt)
        else $error("Skip exceeds the bits left in the word.");

endmodule

/* tb/sv/tb_length_prefixed_bit_deframer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed bit deframer testbench
// Feeds well-formed frame streams packed into 32-bit words, predicts every
// payload byte and compares each output transaction with the prediction.
// ----------------------------------------------------------------------------

module tb_length_prefixed_bit_deframer_unit
    import lpbd_pkg::*;
();

    class frame_byte_scoreboard;

        logic [LPBD_SKIP_W-1:0]            skip_bits;
        bit                                first_seen;
        bit                                in_payload;
        logic [LPBD_LENGTH_FIELD_BITS-1:0] length_acc;
        logic [LPBD_BYTE_BITS-1:0]         byte_acc;
        int unsigned                       acc_bits;
        int unsigned                       bits_left;
        int unsigned                       step_results;
        int unsigned                       failures;
        t_lpbd_result                      expected_bytes[$];

        function new();
            skip_bits    = LPBD_SKIP_RESET;
            first_seen   = 1'b0;
            in_payload   = 1'b0;
            length_acc   = '0;
            byte_acc     = '0;
            acc_bits     = 0;
            bits_left    = 0;
            step_results = 0;
            failures     = 0;
        endfunction

        function void note_skip(logic [LPBD_SKIP_W-1:0] value);
            skip_bits = value;
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= 10) begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
        endfunction

        function void emit(logic [LPBD_BYTE_BITS-1:0] data, int unsigned nbits, bit last,
                           bit empty);
            t_lpbd_result r;
            if (step_results >= LPBD_MAX_RESULTS) begin
                return;
            end
            r.data_byte   = data;
            r.byte_bits   = LPBD_NBITS_W'(nbits);
            r.frame_last  = last;
            r.frame_empty = empty;
            expected_bytes.push_back(r);
            step_results++;
        endfunction

        function void note_word(logic [LPBD_WORD_BITS-1:0] word);
            int unsigned pos;
            pos = first_seen ? 0 : 32'(skip_bits);
            first_seen   = 1'b1;
            step_results = 0;
            for (; pos < LPBD_WORD_BITS; pos++) begin
                if (!in_payload) begin
                    length_acc = {length_acc[LPBD_LENGTH_FIELD_BITS-2:0],
                                  word[LPBD_WORD_BITS-1-pos]};
                    acc_bits++;
                    if (acc_bits == LPBD_LENGTH_FIELD_BITS) begin
                        if (length_acc == '0) begin
                            emit('0, 0, 1'b1, 1'b1);
                        end else begin
                            in_payload = 1'b1;
                            bits_left  = 32'(length_acc);
                        end
                        length_acc = '0;
                        acc_bits   = 0;
                    end
                end else begin
                    byte_acc = {byte_acc[LPBD_BYTE_BITS-2:0], word[LPBD_WORD_BITS-1-pos]};
                    acc_bits++;
                    bits_left--;
                    if (acc_bits == LPBD_BYTE_BITS || bits_left == 0) begin
                        emit(byte_acc << (LPBD_BYTE_BITS - acc_bits), acc_bits,
                             bits_left == 0, 1'b0);
                        if (bits_left == 0) begin
                            in_payload = 1'b0;
                        end
                        byte_acc = '0;
                        acc_bits = 0;
                    end
                end
            end
        endfunction

        function void check_byte(logic [LPBD_BYTE_BITS-1:0] data,
                                 logic [LPBD_NBITS_W-1:0] nbits, logic last, logic empty);
            t_lpbd_result want;
            if (expected_bytes.size() == 0) begin
                note_failure($sformatf("unexpected result data_byte 0x%02h byte_bits %0d",
                                       data, nbits));
                return;
            end
            want = expected_bytes.pop_front();
            if (data !== want.data_byte) begin
                note_failure($sformatf("data_byte expected 0x%02h, got 0x%02h",
                                       want.data_byte, data));
            end
            if (nbits !== want.byte_bits) begin
                note_failure($sformatf("byte_bits expected %0d, got %0d", want.byte_bits, nbits));
            end
            if (last !== want.frame_last) begin
                note_failure($sformatf("frame_last expected %0b, got %0b", want.frame_last, last));
            end
            if (empty !== want.frame_empty) begin
                note_failure($sformatf("frame_empty expected %0b, got %0b",
                                       want.frame_empty, empty));
            end
        endfunction
    endclass

    typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} t_fill;

    localparam int unsigned SETTLE_CYCLES = 3 * LPBD_WORD_BITS;
    localparam int unsigned QUIET_LIMIT   = 2000;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [LPBD_SKIP_W-1:0]    i_cfg_start_skip_bits;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [LPBD_WORD_BITS-1:0] i_stream_word;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic [LPBD_BYTE_BITS-1:0] o_data_byte;
    logic [LPBD_NBITS_W-1:0]   o_byte_bits;
    logic                      o_frame_last;
    logic                      o_frame_empty;

    frame_byte_scoreboard sb;
    bit                   stream_bits[$];
    bit                   idling_on = 1'b1;
    int unsigned          quiet_cycles = 0;

    length_prefixed_bit_deframer_unit DUT (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_start_skip_bits (i_cfg_start_skip_bits),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_stream_word         (i_stream_word),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_data_byte           (o_data_byte),
        .o_byte_bits           (o_byte_bits),
        .o_frame_last          (o_frame_last),
        .o_frame_empty         (o_frame_empty)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void push_length(logic [LPBD_LENGTH_FIELD_BITS-1:0] len);
        for (int k = LPBD_LENGTH_FIELD_BITS - 1; k >= 0; k--) begin
            stream_bits.push_back(len[k]);
        end
    endfunction

    function automatic void push_payload(int unsigned nbits, t_fill fill);
        repeat (nbits) begin
            case (fill)
                FILL_ONES:  stream_bits.push_back(1'b1);
                FILL_ZEROS: stream_bits.push_back(1'b0);
                default:    stream_bits.push_back(1'($urandom_range(0, 1)));
            endcase
        end
    endfunction

    function automatic logic [LPBD_WORD_BITS-1:0] take_word();
        logic [LPBD_WORD_BITS-1:0] word;
        for (int k = LPBD_WORD_BITS - 1; k >= 0; k--) begin
            word[k] = stream_bits.pop_front();
        end
        return word;
    endfunction

    task automatic send_word(logic [LPBD_WORD_BITS-1:0] word);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_stream_word <= word;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_word(word);
        @(negedge i_clk);
    endtask

    task automatic drain_stream();
        while (stream_bits.size() >= LPBD_WORD_BITS) begin
            send_word(take_word());
        end
    endtask

    task automatic send_random_frames(int unsigned words);
        int unsigned len;
        int unsigned pick;
        repeat (words) begin
            while (stream_bits.size() < LPBD_WORD_BITS) begin
                pick = $urandom_range(0, 99);
                if (pick < 12) begin
                    len = 0;
                end else if (pick < 70) begin
                    len = $urandom_range(1, 40);
                end else if (pick < 95) begin
                    len = $urandom_range(41, 300);
                end else begin
                    len = $urandom_range(301, 2000);
                end
                push_length(LPBD_LENGTH_FIELD_BITS'(len));
                push_payload(len, FILL_RANDOM);
            end
            send_word(take_word());
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.expected_bytes.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_skip(logic [LPBD_SKIP_W-1:0] value);
        i_cfg_valid           <= 1'b1;
        i_cfg_start_skip_bits <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.note_skip(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int stall;
        stall       = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                stall--;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 5);
            end
            i_out_ready <= (stall == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_byte(o_data_byte, o_byte_bits, o_frame_last, o_frame_empty);
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_length_prefixed_bit_deframer_unit failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [LPBD_SKIP_W-1:0] first_skip;
        int unsigned            directed_lengths[14];

        directed_lengths      = '{0, 0, 0, 1, 7, 8, 9, 15, 16, 17, 31, 32, 33, 0};
        sb                    = new();
        i_rst_n               = 1'b0;
        i_cfg_valid           = 1'b0;
        i_cfg_start_skip_bits = '0;
        i_in_valid            = 1'b0;
        i_stream_word         = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        case ($urandom_range(0, 3))
            0:       first_skip = '0;
            1:       first_skip = '1;
            default: first_skip = LPBD_SKIP_W'($urandom_range(0, 31));
        endcase
        write_skip(first_skip);

        // Directed frames: empty frames, short and byte-boundary lengths, solid payloads.
        repeat (first_skip) stream_bits.push_back(1'($urandom_range(0, 1)));
        foreach (directed_lengths[i]) begin
            push_length(LPBD_LENGTH_FIELD_BITS'(directed_lengths[i]));
            push_payload(directed_lengths[i], FILL_RANDOM);
        end
        push_length(LPBD_LENGTH_FIELD_BITS'(96));
        push_payload(96, FILL_ONES);
        push_length(LPBD_LENGTH_FIELD_BITS'(96));
        push_payload(96, FILL_ZEROS);
        push_length(LPBD_LENGTH_FIELD_BITS'(12));
        push_payload(12, FILL_RANDOM);
        push_length('0);
        push_length('0);
        push_length(LPBD_LENGTH_FIELD_BITS'(64));
        push_payload(64, FILL_RANDOM);
        drain_stream();

        // Later writes of the skip must leave the stream untouched.
        settle();
        write_skip('0);
        send_random_frames(130);

        settle();
        write_skip('1);
        send_random_frames(130);

        settle();
        write_skip(LPBD_SKIP_W'($urandom_range(0, 31)));
        idling_on = 1'b0;
        send_random_frames(130);

        // A frame of maximum length that the stream never completes.
        push_length('1);
        push_payload(640, FILL_RANDOM);
        drain_stream();

        settle();
        if (sb.expected_bytes.size() != 0) begin
            sb.note_failure($sformatf("%0d expected results never arrived",
                                      sb.expected_bytes.size()));
        end
        if (sb.failures == 0) begin
            $display("tb_length_prefixed_bit_deframer_unit passed");
        end else begin
            $display("tb_length_prefixed_bit_deframer_unit failed");
        end
        $finish;
    end
endmodule
